// ===== rtl/core/bellman_ford_shortest_paths_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the shortest path engine
// Same-cycle and next-cycle implications, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef BELLMAN_FORD_SHORTEST_PATHS_TOP_ASSERT_SVH
`define BELLMAN_FORD_SHORTEST_PATHS_TOP_ASSERT_SVH

`define BFSP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bfsp: same-cycle check failed");

`define BFSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bfsp: next-cycle check failed");

`endif

// ===== rtl/core/bfsp_pkg.sv =====
// ----------------------------------------------------------------------------
// bfsp_pkg
// Shared widths, codes, sequencer states and control structs.
// ----------------------------------------------------------------------------
package bfsp_pkg;

  localparam int VTX_W      = 6;
  localparam int EIDX_W     = 8;
  localparam int DIST_W     = 24;
  localparam int VC_W       = 7;
  localparam int EC_W       = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [VC_W-1:0] VC_RESET = 7'd64;
  localparam logic [EC_W-1:0] EC_RESET = 9'd0;

  localparam logic signed [DIST_W-1:0] DIST_MAX = 24'sh7FFFFF;
  localparam logic signed [DIST_W-1:0] DIST_MIN = 24'sh800000;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_SOLVE = 1'b1
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VERTEX_COUNT = 2'd0,
    CFG_EDGE_COUNT   = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE_RD,
    ST_DIST_RD,
    ST_ADD,
    ST_CMP,
    ST_OUT_RD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic                     clear;
    logic                     wr_en;
    logic [VTX_W-1:0]         wr_addr;
    logic signed [DIST_W-1:0] wr_data;
  } dist_ctl_t;

  typedef struct packed {
    logic                     upd;
    logic signed [DIST_W-1:0] sum;
  } relax_res_t;

endpackage

// ===== rtl/core/bfsp_if.sv =====
// ----------------------------------------------------------------------------
// bfsp channel interfaces
// Input, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bfsp_in_if import bfsp_pkg::*; #(
  parameter int WEIGHT_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [EIDX_W-1:0]             edge_index;
  logic [VTX_W-1:0]              edge_from;
  logic [VTX_W-1:0]              edge_to;
  logic signed [WEIGHT_BITS-1:0] edge_weight;
  logic [VTX_W-1:0]              source_vertex;

  modport source (
    output valid, kind, edge_index, edge_from, edge_to, edge_weight, source_vertex,
    input  ready
  );
  modport sink (
    input  valid, kind, edge_index, edge_from, edge_to, edge_weight, source_vertex,
    output ready
  );
endinterface

interface bfsp_out_if import bfsp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [VTX_W-1:0]         vertex;
  logic signed [DIST_W-1:0] distance;
  logic                     reachable;
  logic                     last;

  modport source (
    output valid, vertex, distance, reachable, last,
    input  ready
  );
  modport sink (
    input  valid, vertex, distance, reachable, last,
    output ready
  );
endinterface

interface bfsp_cfg_if import bfsp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ===== rtl/core/bellman_ford_shortest_paths_top.sv =====
// ----------------------------------------------------------------------------
// bellman_ford_shortest_paths_top
// Single-source shortest path engine over a stored weighted edge list.
//
// in_i carries items: a load beat writes one edge into the edge memory, so
// loads stream at one beat per cycle while the engine is idle. A solve beat
// names a source vertex; the sequencer then relaxes edges 0 .. edge_count-1,
// once per vertex in use, through one shared add/saturate/compare unit. Each
// edge goes through edge read, distance read, add and compare/write. The
// solve then emits one result per vertex on out_o, reading each distance
// before loading the result register, which waits while the receiver is not
// ready; the final result carries last. in_i is not ready while a solve runs.
// cfg_i writes vertex_count (index 0) and edge_count (index 1); write them
// only while the engine is idle.
// Reset sets vertex_count to 64, edge_count to 0 and clears reached flags;
// edge and distance memories hold garbage until written.
// A stalled receiver holds the result register and the sequencer waits.
// ----------------------------------------------------------------------------
`include "bellman_ford_shortest_paths_top_assert.svh"

module bellman_ford_shortest_paths_top import bfsp_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bfsp_in_if.sink   in_i,
  bfsp_cfg_if.sink  cfg_i,
  bfsp_out_if.source out_o
);

  localparam int VA = $clog2(MAX_VERTICES);
  localparam int VW = $clog2(MAX_VERTICES + 1);
  localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int NW = $clog2(MAX_EDGES + 1);

  state_e state_q, state_d;

  logic [VC_W-1:0] vc_q;
  logic [EC_W-1:0] ec_q;
  logic [VW-1:0]   nv_w, nv_q, nv_d;
  logic [NW-1:0]   ne_w, ne_q, ne_d;
  logic [VA-1:0]   pass_q, pass_d;
  logic [EA-1:0]   e_q, e_d;
  logic [VA-1:0]   v_q, v_d;

  logic                     out_valid_q, out_valid_d;
  logic [VTX_W-1:0]         out_vertex_q, out_vertex_d;
  logic signed [DIST_W-1:0] out_dist_q, out_dist_d;
  logic                     out_reach_q, out_reach_d;
  logic                     out_last_q, out_last_d;

  logic in_acc, load_acc, solve_acc, src_ok;
  logic edge_last, pass_last, v_last, out_free, out_load;

  logic                          es_wr_en;
  logic [VTX_W-1:0]              e_tail, e_head;
  logic signed [WEIGHT_BITS-1:0] e_weight;

  dist_ctl_t                dist_ctl;
  logic                     dist_rd_en;
  logic [VA-1:0]            dist_rd_a_addr;
  logic signed [DIST_W-1:0] dist_a, dist_b;
  logic [MAX_VERTICES-1:0]  reached;
  logic                     edge_ok;
  relax_res_t               relax_res;

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= VC_RESET;
      ec_q <= EC_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_VERTEX_COUNT: vc_q <= cfg_i.data[VC_W-1:0];
        CFG_EDGE_COUNT:   ec_q <= cfg_i.data[EC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (vc_q == '0) begin
      nv_w = VW'(1);
    end else if (32'(vc_q) > 32'(MAX_VERTICES)) begin
      nv_w = VW'(MAX_VERTICES);
    end else begin
      nv_w = VW'(vc_q);
    end
    if (32'(ec_q) > 32'(MAX_EDGES)) begin
      ne_w = NW'(MAX_EDGES);
    end else begin
      ne_w = NW'(ec_q);
    end
  end

  // handshake and loop bounds
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign load_acc   = in_acc && (in_i.kind == KIND_LOAD);
  assign solve_acc  = in_acc && (in_i.kind == KIND_SOLVE);
  assign src_ok     = 32'(in_i.source_vertex) < 32'(nv_w);

  assign edge_last = (32'(e_q) + 32'd1) == 32'(ne_q);
  assign pass_last = (32'(pass_q) + 32'd1) == 32'(nv_q);
  assign v_last    = (32'(v_q) + 32'd1) == 32'(nv_q);
  assign out_free  = !out_valid_q || out_o.ready;
  assign out_load  = (state_q == ST_OUT) && out_free;

  // edge memory
  assign es_wr_en = load_acc && (32'(in_i.edge_index) < 32'(MAX_EDGES));

  bfsp_edge_store #(
    .MAX_EDGES  (MAX_EDGES),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_edge_store (
    .clk_i      (clk_i),
    .wr_en_i    (es_wr_en),
    .wr_addr_i  (EA'(in_i.edge_index)),
    .wr_tail_i  (in_i.edge_from),
    .wr_head_i  (in_i.edge_to),
    .wr_weight_i(in_i.edge_weight),
    .rd_en_i    (state_q == ST_EDGE_RD),
    .rd_addr_i  (e_q),
    .rd_tail_o  (e_tail),
    .rd_head_o  (e_head),
    .rd_weight_o(e_weight)
  );

  // distance memory
  always_comb begin
    dist_ctl = '0;
    if (solve_acc) begin
      dist_ctl.clear   = 1'b1;
      dist_ctl.wr_en   = src_ok;
      dist_ctl.wr_addr = in_i.source_vertex;
      dist_ctl.wr_data = '0;
    end else if (state_q == ST_CMP) begin
      dist_ctl.wr_en   = relax_res.upd;
      dist_ctl.wr_addr = e_head;
      dist_ctl.wr_data = relax_res.sum;
    end
  end

  assign dist_rd_en     = (state_q == ST_DIST_RD) || (state_q == ST_OUT_RD);
  assign dist_rd_a_addr = (state_q == ST_OUT_RD) ? v_q : e_tail[VA-1:0];

  bfsp_dist_store #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_dist_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (dist_ctl),
    .rd_en_i    (dist_rd_en),
    .rd_a_addr_i(dist_rd_a_addr),
    .rd_b_addr_i(e_head[VA-1:0]),
    .rd_a_data_o(dist_a),
    .rd_b_data_o(dist_b),
    .reached_o  (reached)
  );

  // relaxation unit
  assign edge_ok = (32'(e_tail) < 32'(nv_q)) && (32'(e_head) < 32'(nv_q))
                && reached[e_tail[VA-1:0]];

  bfsp_relax_unit #(
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_relax_unit (
    .clk_i    (clk_i),
    .add_en_i (state_q == ST_ADD),
    .ok_i     (edge_ok),
    .dist_a_i (dist_a),
    .weight_i (e_weight),
    .dist_b_i (dist_b),
    .reach_b_i(reached[e_head[VA-1:0]]),
    .res_o    (relax_res)
  );

  // sequencer: next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (solve_acc) begin
          state_d = (ne_w == '0) ? ST_OUT_RD : ST_EDGE_RD;
        end
      end
      ST_EDGE_RD: state_d = ST_DIST_RD;
      ST_DIST_RD: state_d = ST_ADD;
      ST_ADD:     state_d = ST_CMP;
      ST_CMP: begin
        state_d = (edge_last && pass_last) ? ST_OUT_RD : ST_EDGE_RD;
      end
      ST_OUT_RD:  state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_d = v_last ? ST_IDLE : ST_OUT_RD;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  // sequencer: counters and result register
  always_comb begin
    nv_d         = nv_q;
    ne_d         = ne_q;
    pass_d       = pass_q;
    e_d          = e_q;
    v_d          = v_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_vertex_d = out_vertex_q;
    out_dist_d   = out_dist_q;
    out_reach_d  = out_reach_q;
    out_last_d   = out_last_q;
    case (state_q)
      ST_IDLE: begin
        if (solve_acc) begin
          nv_d   = nv_w;
          ne_d   = ne_w;
          pass_d = '0;
          e_d    = '0;
          v_d    = '0;
        end
      end
      ST_CMP: begin
        if (edge_last) begin
          e_d = '0;
          if (!pass_last) begin
            pass_d = pass_q + VA'(1);
          end
        end else begin
          e_d = e_q + EA'(1);
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_d  = 1'b1;
          out_vertex_d = VTX_W'(v_q);
          out_reach_d  = reached[v_q];
          out_dist_d   = reached[v_q] ? dist_a : '0;
          out_last_d   = v_last;
          if (!v_last) begin
            v_d = v_q + VA'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      nv_q        <= VW'(1);
      ne_q        <= '0;
      pass_q      <= '0;
      e_q         <= '0;
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nv_q        <= nv_d;
      ne_q        <= ne_d;
      pass_q      <= pass_d;
      e_q         <= e_d;
      v_q         <= v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_vertex_q <= out_vertex_d;
    out_dist_q   <= out_dist_d;
    out_reach_q  <= out_reach_d;
    out_last_q   <= out_last_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.vertex    = out_vertex_q;
  assign out_o.distance  = out_dist_q;
  assign out_o.reachable = out_reach_q;
  assign out_o.last      = out_last_q;

  `BFSP_ASSERT_NEXT(a_solve_blocks_input, clk_i, rst_ni, solve_acc, !in_i.ready)
  `BFSP_ASSERT_SAME(a_unreached_zero, clk_i, rst_ni, out_valid_q && !out_reach_q, out_dist_q == '0)
  `BFSP_ASSERT_SAME(a_loop_in_bounds, clk_i, rst_ni, state_q == ST_CMP, (32'(e_q) < 32'(ne_q)) && (32'(pass_q) < 32'(nv_q)))
  `BFSP_ASSERT_NEXT(a_last_ends_solve, clk_i, rst_ni, out_load && v_last, (state_q == ST_IDLE) && out_valid_q && out_last_q)

endmodule

// ===== rtl/core/bfsp_edge_store.sv =====
// ----------------------------------------------------------------------------
// bfsp_edge_store
// Edge memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bfsp_edge_store import bfsp_pkg::*; #(
  parameter int MAX_EDGES   = 256,
  parameter int WEIGHT_BITS = 16,
  localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [EA-1:0]                 wr_addr_i,
  input  logic [VTX_W-1:0]              wr_tail_i,
  input  logic [VTX_W-1:0]              wr_head_i,
  input  logic signed [WEIGHT_BITS-1:0] wr_weight_i,
  input  logic                          rd_en_i,
  input  logic [EA-1:0]                 rd_addr_i,
  output logic [VTX_W-1:0]              rd_tail_o,
  output logic [VTX_W-1:0]              rd_head_o,
  output logic signed [WEIGHT_BITS-1:0] rd_weight_o
);

  localparam int ENTRY_W = 2 * VTX_W + WEIGHT_BITS;

  logic [ENTRY_W-1:0] mem [MAX_EDGES];
  logic [ENTRY_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_tail_i, wr_head_i, wr_weight_i};
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_tail_o   = rd_q[ENTRY_W-1 -: VTX_W];
  assign rd_head_o   = rd_q[WEIGHT_BITS +: VTX_W];
  assign rd_weight_o = signed'(rd_q[WEIGHT_BITS-1:0]);

endmodule

// ===== rtl/core/bfsp_dist_store.sv =====
// ----------------------------------------------------------------------------
// bfsp_dist_store
// Distance memory with two registered read ports, plus reached flags.
// ----------------------------------------------------------------------------
module bfsp_dist_store import bfsp_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  localparam int VA = $clog2(MAX_VERTICES)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dist_ctl_t                ctl_i,
  input  logic                     rd_en_i,
  input  logic [VA-1:0]            rd_a_addr_i,
  input  logic [VA-1:0]            rd_b_addr_i,
  output logic signed [DIST_W-1:0] rd_a_data_o,
  output logic signed [DIST_W-1:0] rd_b_data_o,
  output logic [MAX_VERTICES-1:0]  reached_o
);

  logic signed [DIST_W-1:0] mem [MAX_VERTICES];
  logic signed [DIST_W-1:0] rd_a_q;
  logic signed [DIST_W-1:0] rd_b_q;
  logic [MAX_VERTICES-1:0]  reached_d;
  logic [MAX_VERTICES-1:0]  reached_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[ctl_i.wr_addr[VA-1:0]] <= ctl_i.wr_data;
    end
    if (rd_en_i) begin
      rd_a_q <= mem[rd_a_addr_i];
      rd_b_q <= mem[rd_b_addr_i];
    end
  end

  always_comb begin
    reached_d = ctl_i.clear ? '0 : reached_q;
    if (ctl_i.wr_en) begin
      reached_d[ctl_i.wr_addr[VA-1:0]] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reached_q <= '0;
    end else begin
      reached_q <= reached_d;
    end
  end

  assign rd_a_data_o = rd_a_q;
  assign rd_b_data_o = rd_b_q;
  assign reached_o   = reached_q;

endmodule

// ===== rtl/core/bfsp_relax_unit.sv =====
// ----------------------------------------------------------------------------
// bfsp_relax_unit
// Shared saturating adder and compare, reused for every edge relaxation.
// ----------------------------------------------------------------------------
module bfsp_relax_unit import bfsp_pkg::*; #(
  parameter int WEIGHT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          add_en_i,
  input  logic                          ok_i,
  input  logic signed [DIST_W-1:0]      dist_a_i,
  input  logic signed [WEIGHT_BITS-1:0] weight_i,
  input  logic signed [DIST_W-1:0]      dist_b_i,
  input  logic                          reach_b_i,
  output relax_res_t                    res_o
);

  localparam int SW = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;

  logic signed [SW-1:0]     sum_w;
  logic signed [DIST_W-1:0] sat_w;
  logic signed [DIST_W-1:0] sum_q;
  logic                     ok_q;

  assign sum_w = SW'(dist_a_i) + SW'(weight_i);

  always_comb begin
    if (sum_w > SW'(DIST_MAX)) begin
      sat_w = DIST_MAX;
    end else if (sum_w < SW'(DIST_MIN)) begin
      sat_w = DIST_MIN;
    end else begin
      sat_w = DIST_W'(sum_w);
    end
  end

  always_ff @(posedge clk_i) begin
    if (add_en_i) begin
      sum_q <= sat_w;
      ok_q  <= ok_i;
    end
  end

  assign res_o.upd = ok_q && (!reach_b_i || (sum_q < dist_b_i));
  assign res_o.sum = sum_q;

endmodule
